// File: hdl/lrb_pkg.sv
package lrb_pkg;

    localparam int SET_W      = 11;
    localparam int WAY_W      = 5;
    localparam int PC_W       = 12;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam int DEF_NUM_SETS      = 2048;
    localparam int DEF_NUM_WAYS      = 16;
    localparam int DEF_TABLE_ENTRIES = 4096;

    localparam logic [CNT_W-1:0] CNT_RESET    = 3'd3;
    localparam logic [CNT_W-1:0] THRESH_RESET = 3'd6;
    localparam logic [CNT_W-1:0] CEIL_RESET   = 3'd7;

    typedef enum logic
    {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } lrb_op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_THRESHOLD = 1'b0,
        CFG_CEILING   = 1'b1
    } lrb_cfg_idx_t;

endpackage

// File: hdl/lrb_in_if.sv
interface lrb_in_if;
    import lrb_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic [PC_W-1:0]   pc_index;
    logic              is_writeback;
    logic              was_hit;

    modport source
    (
        output valid, opcode, set_index, way_index, pc_index, is_writeback, was_hit,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, set_index, way_index, pc_index, is_writeback, was_hit,
        output ready
    );
endinterface

// File: hdl/lrb_out_if.sv
interface lrb_out_if;
    import lrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [WAY_W-1:0]  victim_way;

    modport source
    (
        output valid, victim_way,
        input  ready
    );

    modport sink
    (
        input  valid, victim_way,
        output ready
    );
endinterface

// File: hdl/lrb_ram.sv
module lrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/lrb_rank_logic.sv
module lrb_rank_logic #(
    parameter int NUM_WAYS = lrb_pkg::DEF_NUM_WAYS
) (
    input  logic [NUM_WAYS*$clog2(NUM_WAYS)-1:0] row,
    input  logic [$clog2(NUM_WAYS)-1:0]          touch_way,
    output logic [$clog2(NUM_WAYS)-1:0]          lru_way,
    output logic [NUM_WAYS*$clog2(NUM_WAYS)-1:0] row_next
);
    import lrb_pkg::*;

    localparam int RANK_W = $clog2(NUM_WAYS);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(NUM_WAYS - 1);

    logic [RANK_W-1:0] pivot;

    assign pivot = row[touch_way*RANK_W +: RANK_W];

    // lowest way holding the last rank, way 0 when none does
    always_comb
    begin
        lru_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row[w*RANK_W +: RANK_W] == RANK_LAST)
            begin
                lru_way = RANK_W'(w);
            end
        end
    end

    // promote touched way, age the ones that were more recent
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (RANK_W'(w) == touch_way)
            begin
                row_next[w*RANK_W +: RANK_W] = '0;
            end
            else if (row[w*RANK_W +: RANK_W] < pivot)
            begin
                row_next[w*RANK_W +: RANK_W] = row[w*RANK_W +: RANK_W] + RANK_W'(1);
            end
            else
            begin
                row_next[w*RANK_W +: RANK_W] = row[w*RANK_W +: RANK_W];
            end
        end
    end
endmodule

// File: hdl/lru_replacement_with_pc_bypass.sv
// rsp.valid rises once the taken request has executed in ST_EXEC, later while
//   an earlier result beat is still held back by rsp.ready
// a new request is taken only in ST_IDLE, once the previous one has executed;
//   ST_IDLE does the registered read of the rank row and counter entry,
//   ST_EXEC the write-back; after reset both tables are rewritten one entry per
//   cycle, with req.ready low, until every entry is initialised; config writes still land
module lru_replacement_with_pc_bypass #(
    parameter int NUM_SETS      = lrb_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS      = lrb_pkg::DEF_NUM_WAYS,
    parameter int TABLE_ENTRIES = lrb_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lrb_in_if.sink                          req,
    lrb_out_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [lrb_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [lrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lrb_pkg::*;

    localparam int RANK_W  = $clog2(NUM_WAYS);
    localparam int ROW_W   = NUM_WAYS * RANK_W;
    localparam int SET_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int CNT_AW  = $clog2(TABLE_ENTRIES);
    localparam int SET_XW  = (SET_AW > SET_W) ? SET_AW : SET_W;
    localparam int PC_XW   = (CNT_AW > PC_W) ? CNT_AW : PC_W;
    localparam int WAY_XW  = ((RANK_W > WAY_W) ? RANK_W : WAY_W) + 1;
    localparam int CLR_N   = (NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES;
    localparam int CLR_AW  = $clog2(CLR_N);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_N - 1);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_AW-1:0]  clr_reg, clr_next;
    logic               op_reg, op_next;
    logic [SET_AW-1:0]  set_reg, set_next;
    logic [WAY_XW-1:0]  way_reg, way_next;
    logic [CNT_AW-1:0]  slot_reg, slot_next;
    logic               wb_reg, wb_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    logic [WAY_W-1:0]   victim_reg, victim_next;
    logic [CNT_W-1:0]   thresh_reg, ceil_reg;

    logic [SET_XW-1:0]  set_ext;
    logic [PC_XW-1:0]   pc_ext;
    logic [SET_AW-1:0]  set_in;
    logic [CNT_AW-1:0]  slot_in;

    logic [ROW_W-1:0]   row_q, row_upd, row_init, row_wdata;
    logic [CNT_W-1:0]   cnt_q, cnt_upd, cnt_wdata;
    logic [RANK_W-1:0]  lru_way;
    logic               way_ok, bypass, exec_fire;
    logic               row_we, cnt_we;
    logic [SET_AW-1:0]  row_waddr, row_raddr;
    logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;

    assign set_ext = SET_XW'(req.set_index);
    assign pc_ext  = PC_XW'(req.pc_index);
    assign set_in  = (NUM_SETS > 1) ? set_ext[SET_AW-1:0] : '0;
    assign slot_in = pc_ext[CNT_AW-1:0];

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_init[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
    end

    lrb_rank_logic #(
        .NUM_WAYS (NUM_WAYS)
    ) u_rank (
        .row       (row_q),
        .touch_way (way_reg[RANK_W-1:0]),
        .lru_way   (lru_way),
        .row_next  (row_upd)
    );

    assign way_ok    = way_reg < WAY_XW'(NUM_WAYS);
    assign bypass    = !wb_reg && (cnt_q >= thresh_reg);
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    // saturating predictor counter
    always_comb
    begin
        cnt_upd = cnt_q;
        if (!hit_reg)
        begin
            if (cnt_q < ceil_reg)
            begin
                cnt_upd = cnt_q + CNT_W'(1);
            end
        end
        else if (cnt_q != '0)
        begin
            cnt_upd = cnt_q - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            row_we    = ({1'b0, clr_reg} < (CLR_AW + 1)'(NUM_SETS));
            row_waddr = SET_AW'(clr_reg);
            row_wdata = row_init;
            cnt_we    = ({1'b0, clr_reg} < (CLR_AW + 1)'(TABLE_ENTRIES));
            cnt_waddr = CNT_AW'(clr_reg);
            cnt_wdata = CNT_RESET;
        end
        else
        begin
            row_we    = exec_fire && (op_reg == OP_UPDATE) && way_ok;
            row_waddr = set_reg;
            row_wdata = row_upd;
            cnt_we    = exec_fire && (op_reg == OP_UPDATE) && !wb_reg;
            cnt_waddr = slot_reg;
            cnt_wdata = cnt_upd;
        end
    end

    assign row_raddr = (state_reg == ST_IDLE) ? set_in : set_reg;
    assign cnt_raddr = (state_reg == ST_IDLE) ? slot_in : slot_reg;

    lrb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rank_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_q)
    );

    lrb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            ceil_reg   <= CEIL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_THRESHOLD: thresh_reg <= cfg_data;
                CFG_CEILING:   ceil_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        set_next       = set_reg;
        way_next       = way_reg;
        slot_next      = slot_reg;
        wb_next        = wb_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        victim_next    = victim_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLR_AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    set_next   = set_in;
                    way_next   = WAY_XW'(req.way_index);
                    slot_next  = slot_in;
                    wb_next    = req.is_writeback;
                    hit_next   = req.was_hit;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_UPDATE)
                    begin
                        victim_next = '0;
                    end
                    else if (bypass)
                    begin
                        victim_next = WAY_W'(NUM_WAYS);
                    end
                    else
                    begin
                        victim_next = WAY_W'(lru_way);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        set_reg    <= set_next;
        way_reg    <= way_next;
        slot_reg   <= slot_next;
        wb_reg     <= wb_next;
        hit_reg    <= hit_next;
        victim_reg <= victim_next;
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.victim_way = victim_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one still executing");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (rsp.valid && (state_reg == ST_IDLE)))
        else $error("executed request produced no result beat");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!req.ready && !rsp.valid))
        else $error("traffic during table clear");

    a_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (op_reg == OP_UPDATE)) |=> (rsp.victim_way == '0))
        else $error("update beat carries nonzero way");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!row_we && !cnt_we))
        else $error("table written while idle");
endmodule

// File: tb/tb_lru_replacement_with_pc_bypass.sv
`timescale 1ns / 100ps

module tb_lru_replacement_with_pc_bypass;
    import lrb_pkg::*;

    localparam int NWAYS       = DEF_NUM_WAYS;
    localparam int TIMEOUT_CYC = 200_000;

    typedef struct packed
    {
        lrb_op_t            op;
        logic [SET_W-1:0]   set_idx;
        logic [WAY_W-1:0]   way;
        logic [PC_W-1:0]    pc;
        logic               wb;
        logic               hit;
    } access_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lrb_in_if  req_if();
    lrb_out_if rsp_if();

    lru_replacement_with_pc_bypass u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if.sink),
        .rsp      (rsp_if.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // shadow copy of the ranking and predictor state
    logic [3:0]        set_rank [DEF_NUM_SETS][NWAYS];
    logic [CNT_W-1:0]  pc_cnt [DEF_TABLE_ENTRIES];
    logic [CNT_W-1:0]  thresh_q = THRESH_RESET;
    logic [CNT_W-1:0]  ceil_q   = CEIL_RESET;

    access_t           pending_q [$];
    logic [WAY_W-1:0]  victim_q [$];
    int                pushed_cnt   = 0;
    int                accepted_cnt = 0;
    int                fail_cnt     = 0;
    int                stall_reqs   = 0;
    int                stall_seen   = 0;
    int                stall_left   = 0;
    bit                no_idle      = 1'b0;
    logic              req_taken;
    access_t           taken;
    access_t           nxt;
    logic [WAY_W-1:0]  want_way;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYC * 12);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [WAY_W-1:0] predict_victim(access_t a);
        int               s;
        int               p;
        logic [3:0]       pivot;
        logic [CNT_W-1:0] c;
        logic [WAY_W-1:0] answer;
        s = a.set_idx % DEF_NUM_SETS;
        p = a.pc % DEF_TABLE_ENTRIES;
        answer = '0;
        if (a.op == OP_QUERY)
        begin
            if (!a.wb && pc_cnt[p] >= thresh_q)
                answer = WAY_W'(NWAYS);
            else
                for (int w = NWAYS - 1; w >= 0; w--)
                    if (set_rank[s][w] == 4'(NWAYS - 1))
                        answer = WAY_W'(w);
        end
        else
        begin
            if (!a.wb)
            begin
                c = pc_cnt[p];
                if (!a.hit)
                begin
                    if (c < ceil_q)
                        c = c + 1'b1;
                end
                else if (c > 0)
                    c = c - 1'b1;
                pc_cnt[p] = c;
            end
            if (a.way < NWAYS)
            begin
                pivot = set_rank[s][a.way[3:0]];
                for (int w = 0; w < NWAYS; w++)
                    if (set_rank[s][w] < pivot)
                        set_rank[s][w] = set_rank[s][w] + 1'b1;
                set_rank[s][a.way[3:0]] = '0;
            end
        end
        return answer;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_taken)
        begin
            if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 6))
            begin
                nxt = pending_q.pop_front();
                req_if.valid        <= 1'b1;
                req_if.opcode       <= nxt.op;
                req_if.set_index    <= nxt.set_idx;
                req_if.way_index    <= nxt.way;
                req_if.pc_index     <= nxt.pc;
                req_if.is_writeback <= nxt.wb;
                req_if.was_hit      <= nxt.hit;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // result-side ready, with long holds on request
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (stall_seen != stall_reqs)
        begin
            stall_seen   <= stall_reqs;
            stall_left   <= 400;
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 6);
    end

    // monitor: checks result beats, tracks config and request beats
    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (victim_q.size() == 0)
                begin
                    $error("victim_way: unexpected beat, expected none, actual %0d",
                           rsp_if.victim_way);
                    fail_cnt++;
                end
                else
                begin
                    want_way = victim_q.pop_front();
                    if (rsp_if.victim_way !== want_way)
                    begin
                        $error("victim_way: expected %0d, actual %0d",
                               want_way, rsp_if.victim_way);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_THRESHOLD: thresh_q = cfg_data;
                    CFG_CEILING:   ceil_q   = cfg_data;
                    default:       ;
                endcase
            end
            if (req_if.valid && req_if.ready)
            begin
                taken.op      = lrb_op_t'(req_if.opcode);
                taken.set_idx = req_if.set_index;
                taken.way     = req_if.way_index;
                taken.pc      = req_if.pc_index;
                taken.wb      = req_if.is_writeback;
                taken.hit     = req_if.was_hit;
                victim_q.push_back(predict_victim(taken));
                accepted_cnt++;
            end
            req_taken <= req_if.valid && req_if.ready;
        end
    end

    function automatic void push_access(lrb_op_t op, int s, int w, int p, bit wb, bit hit);
        access_t a;
        a.op      = op;
        a.set_idx = SET_W'(s);
        a.way     = WAY_W'(w);
        a.pc      = PC_W'(p);
        a.wb      = wb;
        a.hit     = hit;
        pending_q.push_back(a);
        pushed_cnt++;
    endfunction

    // hot sets and pcs so that ranks and counters move
    function automatic access_t random_access();
        access_t a;
        a.op      = lrb_op_t'($urandom_range(1));
        a.set_idx = SET_W'(($urandom_range(99) < 75) ? $urandom_range(3) : $urandom);
        a.way     = WAY_W'(($urandom_range(99) < 85) ? $urandom_range(NWAYS - 1)
                                                     : $urandom_range(31, NWAYS));
        a.pc      = PC_W'(($urandom_range(99) < 75) ? $urandom_range(7) : $urandom);
        a.wb      = ($urandom_range(99) < 20);
        a.hit     = 1'($urandom_range(1));
        return a;
    endfunction

    // mostly fill sequences: query, miss fill, then a few hits in the same set
    task automatic push_random_accesses(int n);
        int      k;
        int      hits;
        access_t a;
        k = 0;
        while (k < n)
        begin
            a = random_access();
            if ($urandom_range(99) < 65)
            begin
                push_access(OP_QUERY, a.set_idx, a.way, a.pc, a.wb, a.hit);
                push_access(OP_UPDATE, a.set_idx, a.way, a.pc, a.wb, 1'b0);
                hits = $urandom_range(2);
                for (int h = 0; h < hits; h++)
                    push_access(OP_UPDATE, a.set_idx, $urandom_range(NWAYS - 1),
                                a.pc, 1'b0, 1'b1);
                k += 2 + hits;
            end
            else
            begin
                pending_q.push_back(a);
                pushed_cnt++;
                k++;
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || victim_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(lrb_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] th, logic [CFG_DATA_W-1:0] ce);
        write_reg(CFG_THRESHOLD, th);
        write_reg(CFG_CEILING, ce);
    endtask

    initial
    begin
        for (int s = 0; s < DEF_NUM_SETS; s++)
            for (int w = 0; w < NWAYS; w++)
                set_rank[s][w] = 4'(w);
        for (int p = 0; p < DEF_TABLE_ENTRIES; p++)
            pc_cnt[p] = CNT_RESET;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.opcode        = 1'b0;
        req_if.set_index     = '0;
        req_if.way_index     = '0;
        req_if.pc_index      = '0;
        req_if.is_writeback  = 1'b0;
        req_if.was_hit       = 1'b0;
        rsp_if.ready         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset config
        push_access(OP_QUERY, 0, 0, 0, 1'b0, 1'b0);
        push_access(OP_QUERY, 2047, 31, 4095, 1'b1, 1'b1);
        push_access(OP_UPDATE, 0, 16, 12'h123, 1'b0, 1'b0);
        push_access(OP_UPDATE, 0, 31, 12'h123, 1'b0, 1'b0);
        push_access(OP_UPDATE, 0, 15, 12'h123, 1'b0, 1'b0);
        push_access(OP_QUERY, 0, 0, 12'h123, 1'b0, 1'b0);
        push_access(OP_QUERY, 0, 0, 12'h123, 1'b1, 1'b0);
        push_access(OP_UPDATE, 2047, 0, 12'h123, 1'b1, 1'b1);
        push_access(OP_UPDATE, 2047, 15, 12'h123, 1'b0, 1'b1);
        push_access(OP_QUERY, 2047, 0, 12'h123, 1'b0, 1'b0);
        for (int i = 0; i < 5; i++)
            push_access(OP_UPDATE, 2047, 31, 4095, 1'b0, 1'b0);
        push_access(OP_QUERY, 2047, 0, 4095, 1'b0, 1'b1);
        push_access(OP_UPDATE, 1024, 8, 0, 1'b0, 1'b1);
        push_access(OP_QUERY, 1024, 0, 0, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
            push_access(OP_UPDATE, 1024, 8 + i, 0, 1'b0, 1'b1);
        push_access(OP_QUERY, 1024, 0, 0, 1'b0, 1'b0);
        push_access(OP_QUERY, 1024, 0, 0, 1'b1, 1'b0);
        wait_idle();

        // highest threshold, with a sender pause until drained
        set_config(3'd7, 3'd7);
        push_random_accesses(150);
        wait_idle();
        push_random_accesses(150);
        wait_idle();

        // every non-writeback query bypasses; receiver holds off long
        set_config(3'd0, 3'd1);
        stall_reqs++;
        push_random_accesses(250);
        wait_idle();

        // ceiling below stored counters and a ceiling of zero
        set_config(3'd1, 3'd0);
        push_random_accesses(250);
        wait_idle();

        no_idle = 1'b1;
        set_config(3'd4, 3'd5);
        push_random_accesses(300);
        wait_idle();
        no_idle = 1'b0;

        set_config(3'd2, 3'd3);
        push_random_accesses(300);
        wait_idle();

        set_config(THRESH_RESET, CEIL_RESET);
        stall_reqs++;
        push_random_accesses(300);
        wait_idle();

        repeat (10) @(posedge clk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lrb_pkg.sv
hdl/lrb_in_if.sv
hdl/lrb_out_if.sv
hdl/lrb_ram.sv
hdl/lrb_rank_logic.sv
hdl/lru_replacement_with_pc_bypass.sv
tb/tb_lru_replacement_with_pc_bypass.sv
